>>> sv/isws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isws_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // field widths of the request and result words
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 9;
  localparam int WORD_W = 32;

  typedef logic [IDX_W-1:0]  isws_idx_t;
  typedef logic [WORD_W-1:0] isws_word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_SET  = 3'd2,
    CMD_GET  = 3'd3,
    CMD_FIND = 3'd4
  } isws_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_FULL    = 2'd3
  } isws_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_DONE
  } isws_state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    isws_idx_t        index;
    isws_word_t       data_in;
  } isws_in_t;

  typedef struct packed {
    isws_status_t status;
    isws_word_t   data_out;
    isws_idx_t    position;
    isws_idx_t    count;
  } isws_out_t;

endpackage

`default_nettype wire

>>> sv/isws_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module isws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> sv/isws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module isws_ctrl #(
  parameter int DEPTH      = isws_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = isws_pkg::DATA_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire isws_pkg::isws_in_t    in_payload,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output isws_pkg::isws_out_t        out_payload,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_addr,
  output logic [DATA_WIDTH-1:0]      mem_wdata,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

  isws_pkg::isws_state_t  state_r, state_nxt;
  logic [isws_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  isws_pkg::isws_idx_t    idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0]  key_r, key_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          scan_r, scan_nxt;
  logic                   cmp_valid_r, cmp_valid_nxt;
  logic [CW-1:0]          cmp_idx_r, cmp_idx_nxt;
  isws_pkg::isws_status_t res_status_r, res_status_nxt;
  logic [DATA_WIDTH-1:0]  res_data_r, res_data_nxt;
  logic [CW-1:0]          res_pos_r, res_pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  isws_pkg::isws_out_t    out_r, out_nxt;

  logic [63:0]   din64;
  logic [63:0]   rd64;
  logic [31:0]   idx_m1;
  logic [CW-1:0] cnt_m1;
  logic          idx_ok;
  logic          full;

  assign din64    = 64'(in_payload.data_in);
  assign rd64     = 64'(res_data_r);
  assign idx_m1   = 32'(idx_r) - 32'd1;
  assign cnt_m1   = count_r - 1'b1;
  assign idx_ok   = (idx_r != '0) && (32'(idx_r) <= 32'(count_r));
  assign full     = (32'(count_r) >= 32'(DEPTH));

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isws_pkg::S_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_pos_r    <= res_pos_nxt;
    out_r        <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    cmp_valid_nxt  = cmp_valid_r;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_addr       = '0;
    mem_wdata      = key_r;
    in_ready       = (state_r == isws_pkg::S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      isws_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_payload.command;
          idx_nxt   = in_payload.index;
          key_nxt   = din64[DATA_WIDTH-1:0];
          state_nxt = isws_pkg::S_EXEC;
        end
      end
      isws_pkg::S_EXEC: begin
        res_status_nxt = isws_pkg::ST_OK;
        res_data_nxt   = '0;
        res_pos_nxt    = '0;
        state_nxt      = isws_pkg::S_DONE;
        case (cmd_r)
          isws_pkg::CMD_PUSH: begin
            if (key_r == '0) begin
              res_status_nxt = isws_pkg::ST_ILLEGAL;
            end else if (full) begin
              res_status_nxt = isws_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = count_r[AW-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
          isws_pkg::CMD_POP: begin
            if (count_r == '0) begin
              res_status_nxt = isws_pkg::ST_EMPTY;
            end else begin
              mem_addr  = cnt_m1[AW-1:0];
              count_nxt = cnt_m1;
              state_nxt = isws_pkg::S_RDWAIT;
            end
          end
          isws_pkg::CMD_SET: begin
            if (!idx_ok || key_r == '0) begin
              res_status_nxt = isws_pkg::ST_ILLEGAL;
            end else begin
              mem_we   = 1'b1;
              mem_addr = idx_m1[AW-1:0];
            end
          end
          isws_pkg::CMD_GET: begin
            if (!idx_ok) begin
              res_status_nxt = isws_pkg::ST_ILLEGAL;
            end else begin
              mem_addr  = idx_m1[AW-1:0];
              state_nxt = isws_pkg::S_RDWAIT;
            end
          end
          isws_pkg::CMD_FIND: begin
            // stored words are never zero, so a zero key cannot match
            if (key_r != '0) begin
              scan_nxt      = '0;
              cmp_valid_nxt = 1'b0;
              state_nxt     = isws_pkg::S_SCAN;
            end
          end
          default: begin
            res_status_nxt = isws_pkg::ST_ILLEGAL;
          end
        endcase
      end
      isws_pkg::S_RDWAIT: begin
        res_data_nxt = mem_rdata;
        state_nxt    = isws_pkg::S_DONE;
      end
      isws_pkg::S_SCAN: begin
        // read of the next entry overlaps the compare of the previous one
        if (cmp_valid_r && mem_rdata == key_r) begin
          res_pos_nxt   = cmp_idx_r + 1'b1;
          cmp_valid_nxt = 1'b0;
          state_nxt     = isws_pkg::S_DONE;
        end else if (scan_r < count_r) begin
          mem_addr      = scan_r[AW-1:0];
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = scan_r;
          scan_nxt      = scan_r + 1'b1;
        end else begin
          res_pos_nxt   = '0;
          cmp_valid_nxt = 1'b0;
          state_nxt     = isws_pkg::S_DONE;
        end
      end
      isws_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_nxt.status   = res_status_r;
          out_nxt.data_out = rd64[31:0];
          out_nxt.position = isws_pkg::isws_idx_t'(res_pos_r);
          out_nxt.count    = isws_pkg::isws_idx_t'(count_r);
          state_nxt        = isws_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = isws_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above depth");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == isws_pkg::S_EXEC))
    else $error("memory write outside execute state");

  a_count_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != isws_pkg::S_EXEC) |=> $stable(count_r))
    else $error("count changed outside execute state");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isws_pkg::S_DONE) |-> (32'(res_pos_r) <= 32'(count_r)))
    else $error("find position beyond count");
`endif

endmodule

`default_nettype wire

>>> sv/indexed_stack_with_search_unit.sv
// channel  ports                              payload
// request  in_valid / in_ready / in_payload   command, index, data_in
// result   out_valid / out_ready / out_payload status, data_out, position, count
//
// push, set and rejected requests go from the execute state to the done state;
// pop and get add a read-wait state between the two; find scans one entry per cycle
// (up to count), bounded by the single ram port; find of a zero key skips the scan
// rst_n is synchronous; count clears, the entry ram is not cleared
// one request at a time; a new request is taken while a result waits in the
// output register, and a stalled result holds the sequencer in its final state
`timescale 1ns / 1ps
`default_nettype none

module indexed_stack_with_search_unit #(
  parameter int DEPTH      = isws_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = isws_pkg::DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire isws_pkg::isws_in_t in_payload,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output isws_pkg::isws_out_t     out_payload
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  isws_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  isws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
